// ===== rtl/rmth_pkg.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// rmth_pkg: sequencer state type for the two-heap running median
// State codes of the heap sequencer.
// ---------------------------------------------------------------------------
package rmth_pkg;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_PP_RD,
    ST_PP_CMP,
    ST_SD_RD,
    ST_SD_CMP,
    ST_SD_WR,
    ST_PU_INIT,
    ST_SU_RD,
    ST_SU_CMP,
    ST_SU_WR,
    ST_TOP_RD,
    ST_TOP_WAIT,
    ST_DONE
  } state_t;

endpackage
`default_nettype wire

// ===== rtl/running_median_two_heaps_top.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// running_median_two_heaps_top: streaming running median by two heaps
// Lower max-heap and upper min-heap in two synchronous memories; a sequencer
// runs push, push-pop and sift steps by read-modify-write, one level each.
// ---------------------------------------------------------------------------
//  channel | dir | fields
//  in_     | in  | tdata[15:0] sample
//  out_    | out | tdata[16:0] median_doubled, tuser full_res
//
// An item runs decide, then for a push-pop a top read and a sift-down one level
// at a time, then the push with its sift-up, the top read and done; the heap
// levels set how long it takes.
// Reset clears counts, median and control; heap memories are not cleared.
// One item at a time: in_tready is high only while the sequencer is idle.
// A waiting result is held in the output register until taken.
module running_median_two_heaps_top
  import rmth_pkg::*;
#(
  parameter int HEAP_DEPTH  = 512,
  parameter int SAMPLE_BITS = 16
) (
  input  wire                            clk,
  input  wire                            rst_n,
  input  wire                            in_tvalid,
  output logic                           in_tready,
  input  wire  [((SAMPLE_BITS+7)/8)*8-1:0] in_tdata,  // sample
  output logic                           out_tvalid,
  input  wire                            out_tready,
  output logic [((SAMPLE_BITS+8)/8)*8-1:0] out_tdata, // median_doubled
  output logic                           out_tuser  // full_res
);

  localparam int AW = (HEAP_DEPTH > 1) ? $clog2(HEAP_DEPTH) : 1;
  localparam int CW = $clog2(HEAP_DEPTH + 1);
  localparam int MW = SAMPLE_BITS + 1;
  localparam int OPW = ((SAMPLE_BITS+8)/8)*8;

  typedef logic signed [SAMPLE_BITS-1:0] smp_t;

  // heap memories
  smp_t lo_mem [HEAP_DEPTH];
  smp_t up_mem [HEAP_DEPTH];
  smp_t lo_rd_r, up_rd_r;

  state_t state_r, state_nxt;
  logic [CW-1:0] lo_cnt_r, lo_cnt_nxt, up_cnt_r, up_cnt_nxt;
  logic signed [MW-1:0] med_r, med_nxt;
  logic full_r, full_nxt;
  logic ovalid_r, ovalid_nxt;
  smp_t x_r, x_nxt;        // incoming sample
  smp_t v_r, v_nxt;        // value being sifted
  smp_t mv_r, mv_nxt;      // value to push
  logic sel_r, sel_nxt;    // heap in work: 1 lower
  logic push_lo_r, push_lo_nxt;
  logic [CW-1:0] pos_r, pos_nxt, n_r, n_nxt;
  logic phase_r, phase_nxt;   // sift-down read: 0 left child, 1 right
  smp_t lkid_r, lkid_nxt;

  // memory port control
  logic rd_en;
  logic [AW-1:0] rd_addr;
  logic wr_en;
  logic wr_lo;
  logic [AW-1:0] wr_addr;
  smp_t wr_data;

  smp_t rd_cur;
  assign rd_cur = sel_r ? lo_rd_r : up_rd_r;

  function automatic logic above(smp_t a, smp_t b, logic is_max);
    return is_max ? (a > b) : (a < b);
  endfunction

  always_ff @(posedge clk) begin
    if (rd_en) begin
      lo_rd_r <= lo_mem[rd_addr];
      up_rd_r <= up_mem[rd_addr];
    end
    if (wr_en && wr_lo) lo_mem[wr_addr] <= wr_data;
    if (wr_en && !wr_lo) up_mem[wr_addr] <= wr_data;
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      lo_cnt_r <= '0;
      up_cnt_r <= '0;
      med_r    <= '0;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      lo_cnt_r <= lo_cnt_nxt;
      up_cnt_r <= up_cnt_nxt;
      med_r    <= med_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    full_r    <= full_nxt;
    x_r       <= x_nxt;
    v_r       <= v_nxt;
    mv_r      <= mv_nxt;
    sel_r     <= sel_nxt;
    push_lo_r <= push_lo_nxt;
    pos_r     <= pos_nxt;
    n_r       <= n_nxt;
    phase_r   <= phase_nxt;
    lkid_r    <= lkid_nxt;
  end

  // sequencer
  always_comb begin
    logic signed [MW-1:0] x2;
    logic to_lo;
    logic [CW:0] l, r;
    logic [CW-1:0] par;
    smp_t best;
    logic [CW-1:0] bidx;
    state_nxt   = state_r;
    lo_cnt_nxt  = lo_cnt_r;
    up_cnt_nxt  = up_cnt_r;
    med_nxt     = med_r;
    full_nxt    = full_r;
    ovalid_nxt  = ovalid_r;
    x_nxt       = x_r;
    v_nxt       = v_r;
    mv_nxt      = mv_r;
    sel_nxt     = sel_r;
    push_lo_nxt = push_lo_r;
    pos_nxt     = pos_r;
    n_nxt       = n_r;
    phase_nxt   = phase_r;
    lkid_nxt    = lkid_r;
    rd_en   = 1'b0;
    rd_addr = '0;
    wr_en   = 1'b0;
    wr_lo   = sel_r;
    wr_addr = '0;
    wr_data = v_r;
    in_tready = 1'b0;
    x2 = MW'(x_r) <<< 1;
    to_lo = (x2 <= med_r);
    l = ({1'b0, pos_r} << 1) + 1'b1;
    r = ({1'b0, pos_r} << 1) + 2'd2;
    par = CW'((pos_r - 1'b1) >> 1);
    best = '0;
    bidx = '0;
    if (out_tready) ovalid_nxt = 1'b0;

    case (state_r)
      ST_IDLE: begin
        in_tready = !ovalid_r;
        if (in_tvalid && !ovalid_r) begin
          x_nxt = smp_t'(in_tdata[SAMPLE_BITS-1:0]);
          state_nxt = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        if (lo_cnt_r == '0 && up_cnt_r == '0) begin
          med_nxt = x2;
          to_lo = 1'b1;
        end
        full_nxt = 1'b0;
        mv_nxt = x_r;
        if (lo_cnt_r == up_cnt_r) begin
          push_lo_nxt = to_lo;
          if (to_lo ? (lo_cnt_r >= CW'(HEAP_DEPTH)) : (up_cnt_r >= CW'(HEAP_DEPTH)))
            full_nxt = 1'b1;
          state_nxt = full_nxt ? ST_DONE : ST_PU_INIT;
        end else if (lo_cnt_r > up_cnt_r) begin
          push_lo_nxt = 1'b0;
          if (up_cnt_r >= CW'(HEAP_DEPTH)) begin
            full_nxt = 1'b1;
            state_nxt = ST_DONE;
          end else if (to_lo) begin
            sel_nxt = 1'b1;
            n_nxt = lo_cnt_r;
            state_nxt = ST_PP_RD;
          end else state_nxt = ST_PU_INIT;
        end else begin
          push_lo_nxt = 1'b1;
          if (lo_cnt_r >= CW'(HEAP_DEPTH)) begin
            full_nxt = 1'b1;
            state_nxt = ST_DONE;
          end else if (!to_lo) begin
            sel_nxt = 1'b0;
            n_nxt = up_cnt_r;
            state_nxt = ST_PP_RD;
          end else state_nxt = ST_PU_INIT;
        end
      end
      // push-pop: read the top
      ST_PP_RD: begin
        rd_en = 1'b1;
        rd_addr = '0;
        state_nxt = ST_PP_CMP;
      end
      ST_PP_CMP: begin
        if (!above(rd_cur, x_r, sel_r)) begin
          mv_nxt = x_r;
          state_nxt = ST_PU_INIT;
        end else begin
          mv_nxt = rd_cur;
          v_nxt = x_r;
          pos_nxt = '0;
          phase_nxt = 1'b0;
          wr_en = 1'b1;
          wr_addr = '0;
          wr_data = x_r;
          state_nxt = ST_SD_RD;
        end
      end
      // sift-down: read both children in turn
      ST_SD_RD: begin
        if (l >= {1'b0, n_r}) state_nxt = ST_PU_INIT;
        else begin
          rd_en = 1'b1;
          rd_addr = AW'(l);
          phase_nxt = 1'b0;
          state_nxt = ST_SD_CMP;
        end
      end
      ST_SD_CMP: begin
        if (!phase_r && (r < {1'b0, n_r})) begin
          lkid_nxt = rd_cur;
          rd_en = 1'b1;
          rd_addr = AW'(r);
          phase_nxt = 1'b1;
        end else begin
          if (phase_r) begin
            best = above(lkid_r, rd_cur, sel_r) ? lkid_r : rd_cur;
            bidx = above(lkid_r, rd_cur, sel_r) ? CW'(l) : CW'(r);
          end else begin
            best = rd_cur;
            bidx = CW'(l);
          end
          if (!above(best, v_r, sel_r)) state_nxt = ST_PU_INIT;
          else begin
            // parent slot gets child; value moves down (written each level)
            wr_en = 1'b1;
            wr_addr = AW'(pos_r);
            wr_data = best;
            pos_nxt = bidx;
            state_nxt = ST_SD_WR;
          end
        end
      end
      ST_SD_WR: begin
        wr_en = 1'b1;
        wr_addr = AW'(pos_r);
        wr_data = v_r;
        state_nxt = ST_SD_RD;
      end
      // push: place at end, then sift up
      ST_PU_INIT: begin
        sel_nxt = push_lo_r;
        pos_nxt = push_lo_r ? lo_cnt_r : up_cnt_r;
        v_nxt = mv_r;
        wr_en = 1'b1;
        wr_lo = push_lo_r;
        wr_addr = AW'(push_lo_r ? lo_cnt_r : up_cnt_r);
        wr_data = mv_r;
        if (push_lo_r) lo_cnt_nxt = lo_cnt_r + 1'b1;
        else up_cnt_nxt = up_cnt_r + 1'b1;
        state_nxt = ST_SU_RD;
      end
      ST_SU_RD: begin
        if (pos_r == '0) state_nxt = ST_TOP_RD;
        else begin
          rd_en = 1'b1;
          rd_addr = AW'(par);
          state_nxt = ST_SU_CMP;
        end
      end
      ST_SU_CMP: begin
        if (!above(v_r, rd_cur, sel_r)) state_nxt = ST_TOP_RD;
        else begin
          wr_en = 1'b1;
          wr_addr = AW'(pos_r);
          wr_data = rd_cur;
          pos_nxt = par;
          state_nxt = ST_SU_WR;
        end
      end
      ST_SU_WR: begin
        wr_en = 1'b1;
        wr_addr = AW'(pos_r);
        wr_data = v_r;
        state_nxt = ST_SU_RD;
      end
      // read both tops for the median
      ST_TOP_RD: begin
        rd_en = 1'b1;
        rd_addr = '0;
        state_nxt = ST_TOP_WAIT;
      end
      // equal sizes: sum of tops, else twice the top of the larger heap
      ST_TOP_WAIT: begin
        if (lo_cnt_r == up_cnt_r)
          med_nxt = MW'(lo_rd_r) + MW'(up_rd_r);
        else if (lo_cnt_r > up_cnt_r)
          med_nxt = MW'(lo_rd_r) <<< 1;
        else
          med_nxt = MW'(up_rd_r) <<< 1;
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        ovalid_nxt = 1'b1;
        state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign out_tvalid = ovalid_r;
  assign out_tdata  = OPW'(med_r);
  assign out_tuser  = full_r;

  // a result stays until taken
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata)) else $error("result lost");
  // heap sizes differ by at most one whenever the sequencer is idle
  a_bal: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_IDLE |-> (lo_cnt_r - up_cnt_r <= CW'(1)) || (up_cnt_r - lo_cnt_r <= CW'(1)))
    else $error("heaps unbalanced");
  // no input taken while busy
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != ST_IDLE |-> !in_tready) else $error("ready while busy");

endmodule
`default_nettype wire

// ===== tb/sv/running_median_two_heaps_top_test.sv =====
// ---------------------------------------------------------------------------
// running_median_two_heaps_top_test: running median block check
// Streams signed samples into the block, keeps a two-heap median predictor of
// its own and compares each doubled median and full flag with the prediction.
// ---------------------------------------------------------------------------
module running_median_two_heaps_top_test;

  localparam int DEPTH = 512;
  localparam int SBITS = 16;
  localparam int MAX_CYCLES = 600000;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [15:0] in_tdata;   // sample
  logic        out_tvalid;
  logic        out_tready;
  logic [23:0] out_tdata;  // median_doubled
  logic        out_tuser;  // full_res

  running_median_two_heaps_top #(.HEAP_DEPTH(DEPTH), .SAMPLE_BITS(SBITS)) u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser)
  );

  typedef struct packed {
    logic [16:0] median2;
    logic        full;
  } median_word_t;

  // predictor state
  int          lo_heap [DEPTH];
  int          hi_heap [DEPTH];
  int          lo_cnt;
  int          hi_cnt;
  int          med2;
  median_word_t median_q[$];

  int errors = 0;
  int cycles = 0;
  int send_idle_pct;
  int recv_idle_pct;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // cycle limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > MAX_CYCLES) begin
      $display("status: fail");
      $finish;
    end
  end

  function automatic bit ranks_above(int a, int b, bit is_max);
    return is_max ? (a > b) : (a < b);
  endfunction

  task automatic heap_insert(bit is_max, int v);
    int pos;
    int par;
    int t;
    if (is_max) begin
      pos = lo_cnt;
      lo_heap[pos] = v;
      while (pos > 0) begin
        par = (pos - 1) / 2;
        if (!ranks_above(lo_heap[pos], lo_heap[par], 1'b1)) break;
        t = lo_heap[par]; lo_heap[par] = lo_heap[pos]; lo_heap[pos] = t;
        pos = par;
      end
      lo_cnt++;
    end else begin
      pos = hi_cnt;
      hi_heap[pos] = v;
      while (pos > 0) begin
        par = (pos - 1) / 2;
        if (!ranks_above(hi_heap[pos], hi_heap[par], 1'b0)) break;
        t = hi_heap[par]; hi_heap[par] = hi_heap[pos]; hi_heap[pos] = t;
        pos = par;
      end
      hi_cnt++;
    end
  endtask

  // replace top by v if v loses to it, return the element that leaves
  task automatic heap_swap_top(bit is_max, int v, output int leaving);
    int h[DEPTH];
    int n;
    int pos;
    int l;
    int r;
    int pick;
    int t;
    if (is_max) begin h = lo_heap; n = lo_cnt; end
    else begin h = hi_heap; n = hi_cnt; end
    if (!ranks_above(h[0], v, is_max)) begin
      leaving = v;
      return;
    end
    leaving = h[0];
    h[0] = v;
    pos = 0;
    forever begin
      l = 2 * pos + 1;
      r = l + 1;
      if (l >= n) break;
      if (r < n) begin
        if (!ranks_above(h[l], h[pos], is_max) && !ranks_above(h[r], h[pos], is_max)) break;
        pick = ranks_above(h[l], h[r], is_max) ? l : r;
      end else begin
        if (!ranks_above(h[l], h[pos], is_max)) break;
        pick = l;
      end
      t = h[pick]; h[pick] = h[pos]; h[pos] = t;
      pos = pick;
    end
    if (is_max) lo_heap = h;
    else hi_heap = h;
  endtask

  task automatic predict_median(logic [15:0] raw);
    int x;
    int moved;
    bit to_lo;
    bit full;
    median_word_t w;
    x = $signed(raw);
    full = 1'b0;
    if (lo_cnt == 0 && hi_cnt == 0) med2 = 2 * x;
    to_lo = (2 * x <= med2);
    if (lo_cnt == hi_cnt) begin
      if (to_lo) begin
        if (lo_cnt >= DEPTH) full = 1'b1;
        else begin heap_insert(1'b1, x); med2 = 2 * lo_heap[0]; end
      end else begin
        if (hi_cnt >= DEPTH) full = 1'b1;
        else begin heap_insert(1'b0, x); med2 = 2 * hi_heap[0]; end
      end
    end else if (lo_cnt > hi_cnt) begin
      if (hi_cnt >= DEPTH) full = 1'b1;
      else begin
        if (to_lo) heap_swap_top(1'b1, x, moved);
        else moved = x;
        heap_insert(1'b0, moved);
        med2 = lo_heap[0] + hi_heap[0];
      end
    end else begin
      if (lo_cnt >= DEPTH) full = 1'b1;
      else begin
        if (to_lo) moved = x;
        else heap_swap_top(1'b0, x, moved);
        heap_insert(1'b1, moved);
        med2 = lo_heap[0] + hi_heap[0];
      end
    end
    w.median2 = med2[16:0];
    w.full = full;
    median_q.push_back(w);
  endtask

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    errors++;
  endtask

  // send one word, prediction made at acceptance
  task automatic send_sample(logic [15:0] s);
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= s;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predict_median(s);
  endtask

  // receiver stalls
  always @(posedge clk) begin
    if (!rst_n) out_tready <= 1'b0;
    else out_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // result checker
  always @(posedge clk) begin
    median_word_t w;
    if (rst_n && out_tvalid && out_tready) begin
      if (median_q.size() == 0) report_mismatch("unexpected word", out_tdata[16:0], -1);
      else begin
        w = median_q.pop_front();
        if (out_tdata[16:0] !== w.median2)
          report_mismatch("median_doubled", $signed(out_tdata[16:0]), $signed(w.median2));
        if (out_tuser !== w.full) report_mismatch("full_res", out_tuser, w.full);
      end
    end
  end

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (median_q.size() != 0) @(posedge clk);
  endtask

  // extremes, first sample, ties, both rebalancing sides
  task automatic test_directed();
    logic [15:0] pts[$] = '{16'h8000, 16'h7fff, 16'h0000, 16'hffff, 16'h0001,
                            16'h7fff, 16'h7fff, 16'h8000, 16'h8000, 16'h5555,
                            16'haaaa, 16'h0000, 16'h0000, 16'h7ffe, 16'h8001};
    foreach (pts[i]) send_sample(pts[i]);
  endtask

  task automatic test_random(int n);
    logic [15:0] s;
    repeat (n) begin
      case ($urandom_range(3))
        0: s = 16'($urandom);
        1: s = 16'($urandom_range(20)) - 16'd10;
        2: s = $urandom_range(1) ? 16'h7fff : 16'h8000;
        default: s = 16'($urandom_range(2000)) - 16'd1000;
      endcase
      send_sample(s);
    end
  endtask

  // fill heaps past capacity: sides full on both skews
  task automatic test_fill();
    repeat (2 * DEPTH + 40) begin
      send_sample($urandom_range(1) ? 16'h7fff - 16'($urandom_range(3))
                                    : 16'h8000 + 16'($urandom_range(3)));
    end
    repeat (40) send_sample(16'($urandom));
  endtask

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    lo_cnt = 0;
    hi_cnt = 0;
    med2 = 0;
    send_idle_pct = 32;
    recv_idle_pct = 52;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random(250);
    send_idle_pct = 52;
    recv_idle_pct = 32;
    test_random(250);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_fill();
    wait_drained();
    repeat (100) @(posedge clk);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
